@@ rtl/pdps_pkg.sv @@
`timescale 1ns / 1ps
package pdps_pkg;

    // path command codes
    localparam logic [1:0] OP_MOVE  = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_CURVE = 2'd3;

    // register map, byte address = 4 * index
    localparam int          REG_IDX_W        = 3;
    localparam logic [2:0]  REG_DASH_COUNT   = 3'd0;
    localparam logic [2:0]  REG_DASH_LEN_0   = 3'd1;
    localparam logic [2:0]  REG_DASH_LEN_5   = 3'd6;
    localparam logic [2:0]  REG_PHASE_OFFSET = 3'd7;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int NUM_DASH     = 6;
    localparam int DASH_W       = 24;
    localparam int DASH_COUNT_W = 3;

    localparam logic [DASH_COUNT_W-1:0] DASH_COUNT_RST = 3'd2;
    localparam logic [DASH_W-1:0]       DASH_LEN_RST   = 24'd1024;

    typedef logic [DASH_W-1:0] dash_len_t;

endpackage

@@ rtl/pdps_cmd_if.sv @@
`timescale 1ns / 1ps
interface pdps_cmd_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output operation, output point_x, output point_y,
                    input ready);
    modport sink (input valid, input operation, input point_x, input point_y,
                  output ready);
endinterface

@@ rtl/pdps_piece_if.sv @@
`timescale 1ns / 1ps
interface pdps_piece_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] piece_start_x;
    logic signed [COORD_BITS-1:0] piece_start_y;
    logic signed [COORD_BITS-1:0] piece_end_x;
    logic signed [COORD_BITS-1:0] piece_end_y;
    logic                         last_piece;
    logic                         piece_overflow;

    modport source (output valid, output piece_start_x, output piece_start_y,
                    output piece_end_x, output piece_end_y, output last_piece,
                    output piece_overflow, input ready);
    modport sink (input valid, input piece_start_x, input piece_start_y,
                  input piece_end_x, input piece_end_y, input last_piece,
                  input piece_overflow, output ready);
endinterface

@@ rtl/polyline_dash_pattern_splitter.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake          word
// --------  ---------  -----------------  ----------------------------------------------
// cmd       in         valid/ready        operation, point_x, point_y
// piece     out        valid/ready        start x/y, end x/y, last_piece, piece_overflow
// apb       in         psel/penable       dash pattern and phase offset registers
//
// one command word at a time; cmd.ready is high only while the sequencer is idle
// move: offset modulo through the shared divider, then a seek through the entries
// line/close: squares and a shift/subtract root for the length, then the pattern
// is stepped through; each dash piece gets a handover and four multiply/divide
// passes, one per end point coordinate
// curves, and segments without a current point, are taken without leaving idle
// rst_n clears the pattern state and loads the register reset values
// a full output register stalls the sequencer before the next piece is handed over
module polyline_dash_pattern_splitter #(
    parameter int COORD_BITS       = 24,
    parameter int MAX_DASH_ENTRIES = 6,
    parameter int MAX_PIECES       = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pdps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pdps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    pdps_cmd_if.sink                         cmd,
    pdps_piece_if.source                     piece
);
    import pdps_pkg::*;

    // derived widths
    localparam int C      = COORD_BITS;
    localparam int A_W    = (C > 31) ? 31 : C;             // operand of the squares
    localparam int ROOT_W = A_W + 1;                       // floor root of a*a+b*b
    localparam int LEN_W  = ROOT_W + 1;                    // root shifted back up
    localparam int DIV_W  = (LEN_W > 32) ? 32 : LEN_W;     // divisor after scaling
    localparam int D_W    = (LEN_W > DASH_W) ? LEN_W : DASH_W;
    localparam int TOT_W  = DASH_W + 3;
    localparam int MB_W   = (DIV_W > A_W) ? DIV_W : A_W;
    localparam int PW     = C + MB_W;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int NUM_A  = (PW + 1 > SQ_W) ? PW + 1 : SQ_W;
    localparam int NUM_W  = (NUM_A > D_W) ? NUM_A : D_W;
    localparam int R_A    = (TOT_W > DIV_W) ? TOT_W : DIV_W;
    localparam int R_B    = (R_A > ROOT_W + 2) ? R_A : ROOT_W + 2;
    localparam int R_W    = R_B + 1;
    localparam int IT_A   = (D_W > C) ? D_W : C;
    localparam int IT_MAX = (IT_A > ROOT_W) ? IT_A : ROOT_W;
    localparam int IT_W   = $clog2(IT_MAX + 1);
    localparam int CNT_W  = $clog2(MAX_PIECES + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQA   = 4'd1;   // a*a
    localparam logic [3:0] S_SQB   = 4'd2;   // + b*b
    localparam logic [3:0] S_SQRT  = 4'd3;   // root, one bit a cycle
    localparam logic [3:0] S_LEN   = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;   // one pattern step a cycle unless a piece is pushed
    localparam logic [3:0] S_PUSH  = 4'd6;   // hand the previous piece over
    localparam logic [3:0] S_MUL   = 4'd7;   // |d| * t + len/2
    localparam logic [3:0] S_DLOAD = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;   // quotient, one bit a cycle
    localparam logic [3:0] S_PT    = 4'd10;
    localparam logic [3:0] S_FF    = 4'd11;  // advance without drawing
    localparam logic [3:0] S_MOD   = 4'd12;  // remainder by the pattern total
    localparam logic [3:0] S_SEEK  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    // configuration
    logic [DASH_COUNT_W-1:0] dash_count_reg;
    dash_len_t               dash_len_reg [NUM_DASH];
    dash_len_t               phase_offset_reg;

    // pattern and path state
    logic [3:0]           state_reg, state_next;
    logic [C-1:0]         cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [C-1:0]         sub_x_reg, sub_x_next, sub_y_reg, sub_y_next;
    logic                 has_point_reg, has_point_next;
    logic [2:0]           idx_reg, idx_next;
    dash_len_t            phase_reg, phase_next;

    // segment
    logic [C-1:0]         base_x_reg, base_x_next, base_y_reg, base_y_next;
    logic                 neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [C-1:0]         adx_reg, adx_next, ady_reg, ady_next;
    logic [LEN_W-1:0]     len_reg, len_next, trav_reg, trav_next;
    logic [LEN_W-1:0]     t0_reg, t0_next, t1_reg, t1_next;
    logic [D_W-1:0]       d_reg, d_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [3:0]           mod_ret_reg, mod_ret_next;

    // shared shift/subtract unit
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [R_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]    quo_reg, quo_next;
    logic [IT_W-1:0]      iter_reg, iter_next;

    // pending piece and output register
    logic [1:0]           sel_reg, sel_next;
    logic [C-1:0]         pend_reg [4];
    logic [C-1:0]         pend_wdata;
    logic                 pend_we;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 load_out, load_last;
    logic                 out_valid_reg;
    logic [C-1:0]         out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;
    logic                 out_last_reg, out_ovf_reg;
    logic                 out_free;

    // combinational helpers
    logic [2:0]           n_act;
    logic [TOT_W-1:0]     tot_w;
    logic                 any_dash_w;
    dash_len_t            e_cur, rem_e;
    logic [2:0]           idx_inc;
    logic [LEN_W-1:0]     left_w;
    logic [D_W-1:0]       rem_d, left_d, step_d, ff_left;
    logic                 sh_w, rsh_w;
    logic [DIV_W-1:0]     ls_w, ts_w;
    logic [LEN_W-1:0]     root_len;
    logic [C-1:0]         tgt_x, tgt_y;
    logic [C:0]           dfx, dfy;
    logic [C-1:0]         mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [PW-1:0]        prod_w;
    logic [R_W-1:0]       sq_try, sq_trial, dv_try, dv_div;
    logic [C-1:0]         pt_base, pt_q;
    logic                 pt_neg;
    logic                 cmd_acc;
    logic [REG_IDX_W-1:0] widx;

    assign pready  = 1'b1;
    assign widx    = paddr[APB_ADDR_W-1:2];
    assign cmd_acc = cmd.valid && (state_reg == S_IDLE);
    assign cmd.ready = (state_reg == S_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_count_reg   <= DASH_COUNT_RST;
            for (int i = 0; i < NUM_DASH; i++)
            begin
                dash_len_reg[i] <= DASH_LEN_RST;
            end
            phase_offset_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx) inside
                REG_DASH_COUNT:
                    dash_count_reg <= pwdata[DASH_COUNT_W-1:0];
                [REG_DASH_LEN_0:REG_DASH_LEN_5]:
                    dash_len_reg[widx - REG_DASH_LEN_0] <= pwdata[DASH_W-1:0];
                REG_PHASE_OFFSET:
                    phase_offset_reg <= pwdata[DASH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx) inside
            REG_DASH_COUNT:
                prdata = APB_DATA_W'(dash_count_reg);
            [REG_DASH_LEN_0:REG_DASH_LEN_5]:
                prdata = APB_DATA_W'(dash_len_reg[widx - REG_DASH_LEN_0]);
            REG_PHASE_OFFSET:
                prdata = APB_DATA_W'(phase_offset_reg);
            default:
                prdata = '0;
        endcase
    end

    // active entry count, clamped, and the pattern total
    always_comb
    begin
        n_act = (dash_count_reg > 3'(MAX_DASH_ENTRIES)) ? 3'(MAX_DASH_ENTRIES)
                                                        : dash_count_reg;
        if (n_act < 3'd2)
        begin
            n_act = 3'd2;
        end
        tot_w      = '0;
        any_dash_w = 1'b0;
        for (int i = 0; i < NUM_DASH; i++)
        begin
            if (3'(i) < n_act)
            begin
                tot_w = tot_w + TOT_W'(dash_len_reg[i]);
                if ((i % 2 == 0) && (dash_len_reg[i] != '0))
                begin
                    any_dash_w = 1'b1;
                end
            end
        end
    end

    // pattern step: what is left of the current entry and of the segment
    always_comb
    begin
        e_cur   = (idx_reg < 3'(NUM_DASH)) ? dash_len_reg[idx_reg] : '0;
        rem_e   = (e_cur > phase_reg) ? e_cur - phase_reg : '0;
        idx_inc = (({1'b0, idx_reg} + 4'd1) >= {1'b0, n_act}) ? 3'd0 : idx_reg + 3'd1;
        left_w  = len_reg - trav_reg;
        rem_d   = D_W'(rem_e);
        left_d  = D_W'(left_w);
        step_d  = (rem_d < left_d) ? rem_d : left_d;
        ff_left = d_reg - rem_d;
    end

    // segment geometry and operand scaling
    always_comb
    begin
        tgt_x    = (cmd.operation == OP_CLOSE) ? sub_x_reg : C'(cmd.point_x);
        tgt_y    = (cmd.operation == OP_CLOSE) ? sub_y_reg : C'(cmd.point_y);
        dfx      = {tgt_x[C-1], tgt_x} - {cur_x_reg[C-1], cur_x_reg};
        dfy      = {tgt_y[C-1], tgt_y} - {cur_y_reg[C-1], cur_y_reg};
        sh_w     = ((adx_reg >> 31) != '0) || ((ady_reg >> 31) != '0);
        rsh_w    = (len_reg >> 32) != '0;
        ls_w     = DIV_W'(len_reg >> rsh_w);
        ts_w     = DIV_W'((sel_reg[1] ? t1_reg : t0_reg) >> rsh_w);
        root_len = LEN_W'(quo_reg) << sh_w;
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_SQA:
            begin
                mul_a = C'(A_W'(adx_reg >> sh_w));
                mul_b = MB_W'(A_W'(adx_reg >> sh_w));
            end
            S_SQB:
            begin
                mul_a = C'(A_W'(ady_reg >> sh_w));
                mul_b = MB_W'(A_W'(ady_reg >> sh_w));
            end
            default:
            begin
                mul_a = sel_reg[0] ? ady_reg : adx_reg;
                mul_b = MB_W'(ts_w);
            end
        endcase
        prod_w = PW'(mul_a) * PW'(mul_b);
    end

    // shared shift/subtract step (root and divide)
    always_comb
    begin
        sq_try   = {rem_reg[R_W-3:0], num_reg[NUM_W-1 -: 2]};
        sq_trial = R_W'({quo_reg, 2'b01});
        dv_try   = {rem_reg[R_W-2:0], num_reg[NUM_W-1]};
        dv_div   = (state_reg == S_MOD) ? R_W'(tot_w) : R_W'(ls_w);
        pt_q     = C'(quo_reg);
        pt_base  = sel_reg[0] ? base_y_reg : base_x_reg;
        pt_neg   = sel_reg[0] ? neg_y_reg : neg_x_reg;
        pend_wdata = pt_neg ? pt_base - pt_q : pt_base + pt_q;
    end

    assign out_free = !out_valid_reg || piece.ready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        sub_x_next      = sub_x_reg;
        sub_y_next      = sub_y_reg;
        has_point_next  = has_point_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        base_x_next     = base_x_reg;
        base_y_next     = base_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        adx_next        = adx_reg;
        ady_next        = ady_reg;
        len_next        = len_reg;
        trav_next       = trav_reg;
        t0_next         = t0_reg;
        t1_next         = t1_reg;
        d_next          = d_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        mod_ret_next    = mod_ret_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        iter_next       = iter_reg;
        sel_next        = sel_reg;
        pend_valid_next = pend_valid_reg;
        pend_we         = 1'b0;
        load_out        = 1'b0;
        load_last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.operation)
                        OP_MOVE:
                        begin
                            cur_x_next     = C'(cmd.point_x);
                            cur_y_next     = C'(cmd.point_y);
                            sub_x_next     = C'(cmd.point_x);
                            sub_y_next     = C'(cmd.point_y);
                            has_point_next = 1'b1;
                            idx_next       = '0;
                            phase_next     = '0;
                            if (tot_w != '0)
                            begin
                                num_next     = NUM_W'(D_W'(phase_offset_reg)) << (NUM_W - D_W);
                                rem_next     = '0;
                                iter_next    = IT_W'(D_W);
                                mod_ret_next = S_SEEK;
                                state_next   = S_MOD;
                            end
                        end
                        OP_LINE, OP_CLOSE:
                        begin
                            cur_x_next = tgt_x;
                            cur_y_next = tgt_y;
                            if (has_point_reg)
                            begin
                                base_x_next = cur_x_reg;
                                base_y_next = cur_y_reg;
                                neg_x_next  = dfx[C];
                                neg_y_next  = dfy[C];
                                adx_next    = dfx[C] ? C'(-dfx) : C'(dfx);
                                ady_next    = dfy[C] ? C'(-dfy) : C'(dfy);
                                state_next  = S_SQA;
                            end
                        end
                        default:
                            ;
                    endcase
                end
            end

            S_SQA:
            begin
                num_next   = NUM_W'(prod_w);
                state_next = S_SQB;
            end

            S_SQB:
            begin
                num_next   = (num_reg + NUM_W'(prod_w)) << (NUM_W - SQ_W);
                rem_next   = '0;
                quo_next   = '0;
                iter_next  = IT_W'(ROOT_W);
                state_next = S_SQRT;
            end

            S_SQRT:
            begin
                num_next = num_reg << 2;
                if (sq_try >= sq_trial)
                begin
                    rem_next = sq_try - sq_trial;
                    quo_next = {quo_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sq_try;
                    quo_next = {quo_reg[ROOT_W-2:0], 1'b0};
                end
                iter_next = iter_reg - 1'b1;
                if (iter_reg == IT_W'(1))
                begin
                    state_next = S_LEN;
                end
            end

            S_LEN:
            begin
                len_next = root_len;
                if ((root_len == '0) || (tot_w == '0))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (idx_reg >= n_act)
                    begin
                        idx_next   = '0;
                        phase_next = '0;
                    end
                    trav_next  = '0;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    if (any_dash_w)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        d_next     = D_W'(root_len);
                        state_next = S_FF;
                    end
                end
            end

            S_WALK:
            begin
                if (trav_reg >= len_reg)
                begin
                    state_next = S_FIN;
                end
                else if (!idx_reg[0] && (step_d != '0) && (count_reg >= CNT_W'(MAX_PIECES)))
                begin
                    // piece limit: the rest of the segment only moves the pattern on
                    ovf_next   = 1'b1;
                    d_next     = left_d;
                    state_next = S_FF;
                end
                else
                begin
                    if (!idx_reg[0] && (step_d != '0))
                    begin
                        t0_next    = trav_reg;
                        t1_next    = trav_reg + LEN_W'(step_d);
                        count_next = count_reg + 1'b1;
                        state_next = S_PUSH;
                    end
                    trav_next = trav_reg + LEN_W'(step_d);
                    if (step_d < rem_d)
                    begin
                        phase_next = phase_reg + DASH_W'(step_d);
                    end
                    else
                    begin
                        phase_next = '0;
                        idx_next   = idx_inc;
                    end
                end
            end

            S_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    load_out        = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    sel_next        = '0;
                    state_next      = S_MUL;
                end
            end

            S_MUL:
            begin
                num_next   = NUM_W'(prod_w) + NUM_W'(ls_w >> 1);
                state_next = S_DLOAD;
            end

            S_DLOAD:
            begin
                rem_next   = R_W'(num_reg >> C);
                num_next   = num_reg << (NUM_W - C);
                quo_next   = '0;
                iter_next  = IT_W'(C);
                state_next = S_DIV;
            end

            S_DIV, S_MOD:
            begin
                num_next = num_reg << 1;
                if (dv_try >= dv_div)
                begin
                    rem_next = dv_try - dv_div;
                    quo_next = {quo_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = dv_try;
                    quo_next = {quo_reg[ROOT_W-2:0], 1'b0};
                end
                iter_next = iter_reg - 1'b1;
                if (iter_reg == IT_W'(1))
                begin
                    if (state_reg == S_DIV)
                    begin
                        state_next = S_PT;
                    end
                    else
                    begin
                        d_next     = D_W'(rem_next);
                        state_next = mod_ret_reg;
                    end
                end
            end

            S_PT:
            begin
                pend_we  = 1'b1;
                sel_next = sel_reg + 1'b1;
                if (sel_reg == 2'd3)
                begin
                    pend_valid_next = 1'b1;
                    state_next      = S_WALK;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_FF:
            begin
                if (d_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (d_reg < rem_d)
                begin
                    phase_next = phase_reg + DASH_W'(d_reg);
                    state_next = S_FIN;
                end
                else
                begin
                    phase_next = '0;
                    idx_next   = idx_inc;
                    d_next     = ff_left;
                    // whole pattern turns are folded away by the divider
                    if ((idx_inc == '0) && (R_W'(ff_left) >= R_W'(tot_w)))
                    begin
                        num_next     = NUM_W'(ff_left) << (NUM_W - D_W);
                        rem_next     = '0;
                        iter_next    = IT_W'(D_W);
                        mod_ret_next = S_FF;
                        state_next   = S_MOD;
                    end
                end
            end

            S_SEEK:
            begin
                if (d_reg >= D_W'(e_cur))
                begin
                    d_next   = d_reg - D_W'(e_cur);
                    idx_next = idx_inc;
                end
                else
                begin
                    phase_next = DASH_W'(d_reg);
                    state_next = S_IDLE;
                end
            end

            S_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    load_out        = 1'b1;
                    load_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            sub_x_reg      <= '0;
            sub_y_reg      <= '0;
            has_point_reg  <= 1'b0;
            idx_reg        <= '0;
            phase_reg      <= '0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            iter_reg       <= '0;
            sel_reg        <= '0;
            mod_ret_reg    <= S_IDLE;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            sub_x_reg      <= sub_x_next;
            sub_y_reg      <= sub_y_next;
            has_point_reg  <= has_point_next;
            idx_reg        <= idx_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            iter_reg       <= iter_next;
            sel_reg        <= sel_next;
            mod_ret_reg    <= mod_ret_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        base_x_reg <= base_x_next;
        base_y_reg <= base_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        len_reg    <= len_next;
        trav_reg   <= trav_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        d_reg      <= d_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        if (pend_we)
        begin
            pend_reg[sel_reg] <= pend_wdata;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (piece.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sx_reg   <= pend_reg[0];
            out_sy_reg   <= pend_reg[1];
            out_ex_reg   <= pend_reg[2];
            out_ey_reg   <= pend_reg[3];
            out_last_reg <= load_last;
            out_ovf_reg  <= load_last && ovf_reg;
        end
    end

    assign piece.valid          = out_valid_reg;
    assign piece.piece_start_x  = out_sx_reg;
    assign piece.piece_start_y  = out_sy_reg;
    assign piece.piece_end_x    = out_ex_reg;
    assign piece.piece_end_y    = out_ey_reg;
    assign piece.last_piece     = out_last_reg;
    assign piece.piece_overflow = out_ovf_reg;

endmodule

@@ rtl/pdps_checker.sv @@
`timescale 1ns / 1ps
module pdps_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic [1:0]            cmd_operation,
    input logic                  piece_valid,
    input logic                  piece_ready,
    input logic [COORD_BITS-1:0] piece_start_x,
    input logic                  piece_last,
    input logic                  piece_overflow
);
    import pdps_pkg::*;

    // overflow is only flagged on the closing piece of a segment
    a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid |-> (!piece_overflow || piece_last))
        else $error("overflow flag on a non-final piece");

    // more pieces of the segment follow, so the sequencer is still busy
    a_busy_mid_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (piece_valid && piece_ready && !piece_last) |-> !cmd_ready)
        else $error("idle while a segment is unfinished");

    // a curve changes nothing and leaves the block ready
    a_curve_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && (cmd_operation == OP_CURVE)) |=> cmd_ready)
        else $error("curve command did not return to idle");

    a_piece_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (piece_valid && !piece_ready) |=> (piece_valid && $stable(piece_start_x)))
        else $error("stalled piece word changed");

endmodule

bind polyline_dash_pattern_splitter pdps_checker #(.COORD_BITS(COORD_BITS)) u_pdps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_operation  (cmd.operation),
    .piece_valid    (piece.valid),
    .piece_ready    (piece.ready),
    .piece_start_x  (piece.piece_start_x),
    .piece_last     (piece.last_piece),
    .piece_overflow (piece.piece_overflow)
);

@@ tb/pdps_piece_checker.sv @@
`timescale 1ns / 1ps
module pdps_piece_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    pdps_cmd_if         cmd,
    pdps_piece_if       piece,
    output int          errors,
    output int          pending
);
    import pdps_pkg::*;

    typedef struct packed {
        logic [23:0] sx;
        logic [23:0] sy;
        logic [23:0] ex;
        logic [23:0] ey;
        logic        last;
        logic        ovf;
    } dash_piece_t;

    localparam int PIECE_CAP = 64;

    dash_piece_t piece_q[$];

    // shadow registers
    logic [2:0]  cfg_count;
    logic [63:0] cfg_len[6];
    logic [63:0] cfg_offset;

    // shadow path state
    longint      cur_x, cur_y, sub_x, sub_y;
    bit          have_point;
    int unsigned pat_idx;
    logic [63:0] pat_phase;

    function automatic int unsigned entries_used();
        int unsigned n;
        n = cfg_count;
        if (n > 6) n = 6;
        if (n < 2) n = 2;
        return n;
    endfunction

    function automatic logic [63:0] pattern_sum(int unsigned n);
        logic [63:0] s;
        s = 0;
        for (int i = 0; i < n; i++) s += cfg_len[i];
        return s;
    endfunction

    function automatic int unsigned step_idx(int unsigned i, int unsigned n);
        return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] lerp(longint base, longint d, logic [63:0] t,
                                         logic [63:0] len);
        logic [63:0] mag, ts, ls, q;
        mag = (d < 0) ? -d : d;
        ts = t;
        ls = len;
        while (ls > 64'hFFFF_FFFF)
        begin
            ls >>= 1;
            ts >>= 1;
        end
        if (ls == 0) return base[23:0];
        q = (mag * ts + ls / 2) / ls;
        return (d < 0) ? 24'(base - longint'(q)) : 24'(base + longint'(q));
    endfunction

    function automatic void seek_start();
        int unsigned n;
        logic [63:0] tot, p;
        n = entries_used();
        tot = pattern_sum(n);
        pat_idx = 0;
        pat_phase = 0;
        if (tot == 0) return;
        p = cfg_offset % tot;
        while (p >= cfg_len[pat_idx])
        begin
            p -= cfg_len[pat_idx];
            pat_idx = step_idx(pat_idx, n);
        end
        pat_phase = p;
    endfunction

    function automatic void skip_ahead(logic [63:0] d, int unsigned n, logic [63:0] tot);
        logic [63:0] e, rem;
        while (d > 0)
        begin
            e = cfg_len[pat_idx];
            rem = (e > pat_phase) ? e - pat_phase : 0;
            if (d < rem)
            begin
                pat_phase += d;
                return;
            end
            d -= rem;
            pat_phase = 0;
            pat_idx = step_idx(pat_idx, n);
            if (pat_idx == 0 && d >= tot) d %= tot;
        end
    endfunction

    // walks one straight segment and queues the visible pieces
    function automatic void split_segment(longint x1, longint y1, longint x2, longint y2);
        int unsigned n, sh;
        logic [63:0] tot, adx, ady, a, b, len, trav, e, rem, left, stp;
        longint dx, dy;
        bit drawn;
        dash_piece_t segs[$];
        dash_piece_t p;
        n = entries_used();
        tot = pattern_sum(n);
        dx = x2 - x1;
        dy = y2 - y1;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        sh = 0;
        while ((adx >> sh) > 64'h7FFF_FFFF || (ady >> sh) > 64'h7FFF_FFFF) sh++;
        a = adx >> sh;
        b = ady >> sh;
        len = int_root(a * a + b * b) << sh;
        if (len == 0 || tot == 0) return;
        if (pat_idx >= n)
        begin
            pat_idx = 0;
            pat_phase = 0;
        end
        drawn = 0;
        for (int i = 0; i < n; i += 2) if (cfg_len[i] != 0) drawn = 1;
        if (!drawn)
        begin
            skip_ahead(len, n, tot);
            return;
        end
        trav = 0;
        while (trav < len)
        begin
            e = cfg_len[pat_idx];
            rem = (e > pat_phase) ? e - pat_phase : 0;
            left = len - trav;
            stp = (rem < left) ? rem : left;
            if (pat_idx[0] == 1'b0 && stp > 0)
            begin
                if (segs.size() >= PIECE_CAP)
                begin
                    segs[segs.size() - 1].ovf = 1'b1;
                    skip_ahead(left, n, tot);
                    break;
                end
                p.sx = lerp(x1, dx, trav, len);
                p.sy = lerp(y1, dy, trav, len);
                p.ex = lerp(x1, dx, trav + stp, len);
                p.ey = lerp(y1, dy, trav + stp, len);
                p.last = 1'b0;
                p.ovf = 1'b0;
                segs = {segs, p};
            end
            trav += stp;
            if (stp < rem) pat_phase += stp;
            else
            begin
                pat_phase = 0;
                pat_idx = step_idx(pat_idx, n);
            end
        end
        if (segs.size() > 0) segs[segs.size() - 1].last = 1'b1;
        piece_q = {piece_q, segs};
    endfunction

    function automatic void path_command(logic [1:0] op, logic signed [23:0] px,
                                         logic signed [23:0] py);
        longint x, y;
        x = px;
        y = py;
        case (op)
            OP_MOVE:
            begin
                cur_x = x;
                sub_x = x;
                cur_y = y;
                sub_y = y;
                have_point = 1;
                seek_start();
            end
            OP_LINE:
            begin
                if (have_point) split_segment(cur_x, cur_y, x, y);
                cur_x = x;
                cur_y = y;
            end
            OP_CLOSE:
            begin
                if (have_point) split_segment(cur_x, cur_y, sub_x, sub_y);
                cur_x = sub_x;
                cur_y = sub_y;
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dash_piece_t want;
        logic [2:0]  ridx;
        if (!rst_n)
        begin
            cfg_count = DASH_COUNT_RST;
            for (int i = 0; i < 6; i++) cfg_len[i] = DASH_LEN_RST;
            cfg_offset = 0;
            cur_x = 0;
            cur_y = 0;
            sub_x = 0;
            sub_y = 0;
            have_point = 0;
            pat_idx = 0;
            pat_phase = 0;
            errors = 0;
            piece_q.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                ridx = paddr[4:2];
                if (ridx == REG_DASH_COUNT) cfg_count = pwdata[2:0];
                else if (ridx == REG_PHASE_OFFSET) cfg_offset = pwdata[23:0];
                else cfg_len[ridx - REG_DASH_LEN_0] = pwdata[23:0];
            end
            if (piece.valid && piece.ready)
            begin
                if (piece_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected piece %0d,%0d -> %0d,%0d",
                                 piece.piece_start_x, piece.piece_start_y,
                                 piece.piece_end_x, piece.piece_end_y);
                end
                else
                begin
                    want = piece_q.pop_front();
                    if (piece.piece_start_x !== want.sx || piece.piece_start_y !== want.sy
                        || piece.piece_end_x !== want.ex || piece.piece_end_y !== want.ey
                        || piece.last_piece !== want.last
                        || piece.piece_overflow !== want.ovf)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display(
                                "exp %0d,%0d>%0d,%0d l%0b o%0b got %0d,%0d>%0d,%0d l%0b o%0b",
                                $signed(want.sx), $signed(want.sy), $signed(want.ex),
                                $signed(want.ey), want.last, want.ovf,
                                piece.piece_start_x, piece.piece_start_y,
                                piece.piece_end_x, piece.piece_end_y,
                                piece.last_piece, piece.piece_overflow);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                path_command(cmd.operation, cmd.point_x, cmd.point_y);
            pending = piece_q.size();
        end
    end
endmodule

@@ tb/polyline_dash_pattern_splitter_tb.sv @@
`timescale 1ns / 1ps
module polyline_dash_pattern_splitter_tb;
    import pdps_pkg::*;

    // worst case: 64 pieces per word, each with four multiply/divide passes plus receiver stalls
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pieces_owed;
    int          send_gap_pct;
    int          stall_pct;
    longint      cycles;
    logic signed [23:0] pen_x, pen_y;

    pdps_cmd_if   cmd ();
    pdps_piece_if piece ();

    polyline_dash_pattern_splitter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd),
        .piece   (piece)
    );

    pdps_piece_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .cmd     (cmd),
        .piece   (piece),
        .errors  (fail_count),
        .pending (pieces_owed)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls, redrawn every falling edge
    always @(negedge clk)
        piece.ready = ($urandom_range(0, 99) >= stall_pct);

    // register write: setup cycle, then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic load_pattern(logic [2:0] count, logic [23:0] l0, logic [23:0] l1,
                                logic [23:0] l2, logic [23:0] l3, logic [23:0] l4,
                                logic [23:0] l5, logic [23:0] offset);
        reg_write(REG_DASH_COUNT, {29'd0, count});
        reg_write(REG_DASH_LEN_0,     {8'd0, l0});
        reg_write(REG_DASH_LEN_0 + 1, {8'd0, l1});
        reg_write(REG_DASH_LEN_0 + 2, {8'd0, l2});
        reg_write(REG_DASH_LEN_0 + 3, {8'd0, l3});
        reg_write(REG_DASH_LEN_0 + 4, {8'd0, l4});
        reg_write(REG_DASH_LEN_5,     {8'd0, l5});
        reg_write(REG_PHASE_OFFSET,   {8'd0, offset});
    endtask

    // one command word; valid stays high across back to back words
    task automatic send_word(logic [1:0] op, logic signed [23:0] x, logic signed [23:0] y);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            cmd.valid = 1'b0;
            @(negedge clk);
        end
        cmd.valid = 1'b1;
        cmd.operation = op;
        cmd.point_x = x;
        cmd.point_y = y;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        @(negedge clk);
        cmd.valid = 1'b0;
        if (op == OP_MOVE || op == OP_LINE)
        begin
            pen_x = x;
            pen_y = y;
        end
    endtask

    // drain every owed piece, then give a move or an empty segment time to finish
    task automatic settle();
        while (pieces_owed != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic logic signed [23:0] near(logic signed [23:0] c, int span);
        return c + 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // random path: a move, then mostly nearby lines, with some moves and closes,
    // sprinkled with curves and far jumps
    task automatic random_path(int words, int span);
        int r;
        send_word(OP_MOVE, near(pen_x, span), near(pen_y, span));
        for (int i = 1; i < words; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_word(OP_MOVE, near(pen_x, span), near(pen_y, span));
            else if (r < 12)
                send_word(OP_CURVE, 24'($urandom), 24'($urandom));
            else if (r < 22)
                send_word(OP_CLOSE, 24'($urandom), 24'($urandom));
            else if (r < 25)
                send_word(OP_LINE, 24'($urandom), 24'($urandom));
            else
                send_word(OP_LINE, near(pen_x, span), near(pen_y, span));
        end
    endtask

    function automatic logic [23:0] rnd_len(int hi);
        return 24'($urandom_range(1, hi));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd.valid = 1'b0;
        cmd.operation = OP_CURVE;
        cmd.point_x = '0;
        cmd.point_y = '0;
        piece.ready = 1'b0;
        pen_x = '0;
        pen_y = '0;
        cycles = 0;
        send_gap_pct = 11;
        stall_pct = 54;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset pattern: 1024 dash, 1024 gap
        send_word(OP_LINE, 24'sd100, 24'sd100);        // no current point yet
        send_word(OP_CLOSE, 24'sd0, 24'sd0);           // still no current point
        send_word(OP_CURVE, 24'hFFFFFF, 24'hFFFFFF);
        send_word(OP_MOVE, 24'sd0, 24'sd0);
        send_word(OP_LINE, 24'sd5000, 24'sd0);         // phase carries past the end
        send_word(OP_LINE, 24'sd5000, 24'sd3000);
        send_word(OP_LINE, 24'sd5000, 24'sd3000);      // zero length
        send_word(OP_CLOSE, 24'sd0, 24'sd0);           // diagonal back to start
        send_word(OP_CLOSE, 24'sd0, 24'sd0);           // zero length close
        send_word(OP_MOVE, 24'sh7FFFFF, 24'sh7FFFFF);
        send_word(OP_LINE, 24'sh7FFFFE, 24'sh7FFFFF);  // shorter than one dash
        send_word(OP_LINE, -24'sd300, 24'sh7FFFFF);    // piece limit reached
        send_word(OP_MOVE, 24'sh800000, 24'sh7FFFFF);
        send_word(OP_LINE, 24'sh7FFFFF, 24'sh800000);  // widest diagonal
        send_word(OP_CLOSE, 24'sh555555, 24'shAAAAAA);
        send_word(OP_CURVE, 24'sh000000, 24'sh000000);
        settle();

        // short dash, offset inside the gap
        load_pattern(3'd2, 24'd300, 24'd200, 24'd1, 24'd1, 24'd1, 24'd1, 24'd450);
        random_path(55, 3000);
        settle();

        // count above the limit, zero entries skipped, widest entry, offset lands in the widest entry
        load_pattern(3'd7, 24'd0, 24'd700, 24'd500, 24'd0, 24'hFFFFFF, 24'd900,
                     24'hFFFFFF);
        random_path(45, 4000);
        settle();

        send_gap_pct = 54;
        stall_pct = 11;
        // odd count, lengths over the whole field
        load_pattern(3'd3, 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        random_path(30, 8_000_000);
        settle();

        // dash entries all zero: nothing drawn, pattern still moves
        load_pattern(3'd4, 24'd0, 24'd500, 24'd0, 24'd300, 24'd7, 24'd7, 24'd100);
        random_path(15, 3000);
        settle();
        // count below the minimum of two and both used entries zero
        load_pattern(3'd0, 24'd0, 24'd0, 24'd7, 24'd7, 24'd7, 24'd7, 24'd0);
        random_path(10, 3000);
        settle();

        // count lowered while the index sits high: restart at the next segment
        load_pattern(3'd6, rnd_len(2048), rnd_len(2048), rnd_len(2048),
                     rnd_len(2048), rnd_len(2048), rnd_len(2048), 24'($urandom));
        send_word(OP_MOVE, 24'sd0, 24'sd0);
        send_word(OP_LINE, 24'sd7000, 24'sd0);
        settle();
        reg_write(REG_DASH_COUNT, 32'd2);
        reg_write(REG_DASH_LEN_0, 32'd5);               // phase may now sit past its entry
        send_word(OP_LINE, 24'sd7000, 24'sd4000);
        random_path(50, 2500);
        settle();

        send_gap_pct = 0;
        stall_pct = 0;
        // tiny entries: many pieces, some segments hit the piece limit
        load_pattern(3'd4, rnd_len(8), rnd_len(8), rnd_len(8), rnd_len(8),
                     rnd_len(8), rnd_len(8), 24'd3);
        random_path(30, 400);
        settle();

        // random pattern, no idling
        load_pattern(3'($urandom_range(2, 6)), rnd_len(1500), rnd_len(1500),
                     rnd_len(1500), rnd_len(1500), rnd_len(1500), rnd_len(1500),
                     24'($urandom_range(0, 9000)));
        random_path(80, 3000);
        settle();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ polyline_dash_pattern_splitter.f @@
rtl/pdps_pkg.sv
rtl/pdps_cmd_if.sv
rtl/pdps_piece_if.sv
rtl/polyline_dash_pattern_splitter.sv
rtl/pdps_checker.sv
tb/pdps_piece_checker.sv
tb/polyline_dash_pattern_splitter_tb.sv
